### design/indexed_array_list_core_defines.svh
// assertion macros shared by the list core
`ifndef INDEXED_ARRAY_LIST_CORE_DEFINES_SVH
`define INDEXED_ARRAY_LIST_CORE_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define IAL_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// implication checked in the same cycle
`define IAL_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication checked in the following cycle
`define IAL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ial_pkg.sv
package ial_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int OP_W     = 3;
    localparam int POS_W    = 5;
    localparam int LEN_W    = 6;
    localparam int STAT_W   = 2;
    localparam int COUNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W    = $clog2(CAPACITY);
    // compare width wide enough for both a position and a count
    localparam int CMP_W    = (COUNT_W > POS_W) ? COUNT_W : POS_W;

    typedef logic signed [DATA_W-1:0] data_t;

    typedef enum logic [OP_W-1:0] {
        OP_APPEND = 3'd0,
        OP_POP    = 3'd1,
        OP_DELETE = 3'd2,
        OP_INSERT = 3'd3,
        OP_READ   = 3'd4
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_DELETE
    } cell_kind_t;

    typedef struct packed {
        logic [OP_W-1:0]  operation;
        logic [POS_W-1:0] position;
        data_t            item_value;
    } req_t;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  length_now;
        data_t             read_value;
    } rsp_t;

    // broadcast to every cell of the row
    typedef struct packed {
        cell_kind_t       kind;
        logic [CMP_W-1:0] pos;
        data_t            value;
    } cell_ctrl_t;

endpackage

### design/ial_cell.sv
module ial_cell (
    input  logic                     clk,
    input  ial_pkg::cell_ctrl_t      ctrl,
    input  logic [ial_pkg::CMP_W-1:0] idx,
    input  ial_pkg::data_t           below,
    input  ial_pkg::data_t           above,
    output ial_pkg::data_t           entry
);
    import ial_pkg::*;

    data_t data_reg;
    data_t data_next;

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.kind)
            CELL_INSERT:
            begin
                if (idx > ctrl.pos)
                begin
                    data_next = below;
                end
                else if (idx == ctrl.pos)
                begin
                    data_next = ctrl.value;
                end
            end
            CELL_DELETE:
            begin
                if (idx >= ctrl.pos)
                begin
                    data_next = above;
                end
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign entry = data_reg;

endmodule

### design/ial_chain.sv
module ial_chain (
    input  logic                clk,
    input  ial_pkg::cell_ctrl_t ctrl,
    output ial_pkg::data_t      rd_data
);
    import ial_pkg::*;

    data_t cell_data [CAPACITY];

    for (genvar g = 0; g < CAPACITY; g++)
    begin : g_cell
        data_t below_w;
        data_t above_w;

        if (g == 0)
        begin : g_first
            assign below_w = '0;
        end
        else
        begin : g_lower
            assign below_w = cell_data[g-1];
        end

        if (g == CAPACITY - 1)
        begin : g_last
            assign above_w = '0;
        end
        else
        begin : g_upper
            assign above_w = cell_data[g+1];
        end

        ial_cell u_cell (
            .clk   (clk),
            .ctrl  (ctrl),
            .idx   (CMP_W'(g)),
            .below (below_w),
            .above (above_w),
            .entry (cell_data[g])
        );
    end

    // read tap selected by the requested position
    assign rd_data = cell_data[ctrl.pos[IDX_W-1:0]];

endmodule

### design/indexed_array_list_core.sv
// channel  | valid / ready          | payload | direction
// request  | req_valid / req_ready  | req     | in
// response | rsp_valid / rsp_ready  | rsp     | out
//
// one transaction per cycle while req_ready is high: the cell row shifts or writes at the accept edge
// the response appears in the output register in the cycle after acceptance
// reset clears the length and the output valid; cell contents stay undefined
// req_ready is high whenever the output register is empty or being drained
// a stalled response holds the request side only, no transaction is lost
module indexed_array_list_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  ial_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output ial_pkg::rsp_t rsp
);
    import ial_pkg::*;
    `include "indexed_array_list_core_defines.svh"

    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    rsp_t               out_reg;
    rsp_t               out_next;

    cell_ctrl_t         ctrl;
    cell_kind_t         kind;
    status_t            status;
    data_t              rd_data;
    data_t              rd_value;
    logic               accept;
    logic               full;
    logic               empty;
    logic [CMP_W-1:0]   pos_ext;
    logic [CMP_W-1:0]   count_ext;
    logic [CMP_W-1:0]   cell_pos;

    assign req_ready = !out_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign full      = (count_reg == COUNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign pos_ext   = CMP_W'(req.position);
    assign count_ext = CMP_W'(count_reg);

    // append is an insert at the tail
    assign cell_pos  = (req.operation == OP_APPEND) ? count_ext : pos_ext;

    // decode the operation against the current length
    always_comb
    begin
        kind       = CELL_HOLD;
        status     = ST_OK;
        count_next = count_reg;
        rd_value   = '0;
        case (req.operation)
            OP_APPEND:
            begin
                if (full)
                begin
                    status = ST_FULL;
                end
                else
                begin
                    kind       = CELL_INSERT;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else
                begin
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_DELETE:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_ext >= count_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    kind       = CELL_DELETE;
                    count_next = count_reg - COUNT_W'(1);
                end
            end
            OP_INSERT:
            begin
                // full is checked before the index
                if (full)
                begin
                    status = ST_FULL;
                end
                else if (pos_ext > count_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    kind       = CELL_INSERT;
                    count_next = count_reg + COUNT_W'(1);
                end
            end
            OP_READ:
            begin
                if (empty)
                begin
                    status = ST_EMPTY;
                end
                else if (pos_ext >= count_ext)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_value = rd_data;
                end
            end
            default:
            begin
                // unused codes leave the list alone
                status = ST_OK;
            end
        endcase
    end

    // cells only move on an accepted transaction
    assign ctrl = '{kind: (accept ? kind : CELL_HOLD), pos: cell_pos, value: req.item_value};

    ial_chain u_chain (
        .clk     (clk),
        .ctrl    (ctrl),
        .rd_data (rd_data)
    );

    // output register, refilled on accept, drained on rsp_ready
    always_comb
    begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_next.status     = status;
            out_next.length_now = LEN_W'(count_next);
            out_next.read_value = rd_value;
            out_valid_next      = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                count_reg <= count_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `IAL_ASSERT_ALWAYS(a_count_cap, count_reg <= COUNT_W'(CAPACITY), "length above capacity")

    `IAL_ASSERT_NEXT(a_append_grows, accept && req.operation == OP_APPEND && !full,
        count_reg == $past(count_reg) + COUNT_W'(1), "append did not grow the list")

    `IAL_ASSERT_NEXT(a_error_holds, accept && status != ST_OK,
        $stable(count_reg), "failed operation changed the length")

    `IAL_ASSERT_SAME(a_read_zero, out_valid_reg && out_reg.status != ST_OK,
        out_reg.read_value == '0, "read value set on an error")

endmodule
